### sv/hilbert_curve_convert_top_defines.svh
// ---------------------------------------------------------------------------
// Hilbert converter assertion macros
// Clocked assertion helpers used by the converter top level.
// ---------------------------------------------------------------------------
`ifndef HILBERT_CURVE_CONVERT_TOP_DEFINES_SVH
`define HILBERT_CURVE_CONVERT_TOP_DEFINES_SVH

// checked outside reset only
`define HCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define HCC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/hcc_pkg.sv
// ---------------------------------------------------------------------------
// Hilbert converter package
// Pipeline word type, constants and mask helpers.
// ---------------------------------------------------------------------------
package hcc_pkg;

  localparam int COORD_W = 16;
  localparam int INDEX_W = 32;
  localparam int ORDER_W = 5;
  localparam int HW_LEVELS = 16;

  localparam logic [ORDER_W-1:0] GRID_ORDER_RESET = 5'd16;

  localparam logic MODE_TO_INDEX = 1'b0;
  localparam logic MODE_TO_COORD = 1'b1;

  // acc holds the distance being built (to index) or the source index (to coordinates)
  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [INDEX_W-1:0] acc;
  } hcc_word_t;

  function automatic logic [COORD_W-1:0] coord_mask(input logic [ORDER_W-1:0] ord);
    logic [COORD_W-1:0] m;
    for (int i = 0; i < COORD_W; i++) begin
      m[i] = (ORDER_W'(i) < ord);
    end
    return m;
  endfunction

  function automatic logic [INDEX_W-1:0] index_mask(input logic [ORDER_W-1:0] ord);
    logic [INDEX_W-1:0] m;
    for (int i = 0; i < INDEX_W; i++) begin
      m[i] = (ORDER_W'(i / 2) < ord);
    end
    return m;
  endfunction

endpackage

### sv/hilbert_curve_convert_top.sv
// Throughput: one word per cycle; one register stage per curve level, whole pipe stalls
// together when the result word is held.
// Reset: synchronous, clears all stage valid bits and sets grid_order to 16.
// ---------------------------------------------------------------------------
// Hilbert curve converter
// Coordinates to curve index and back, one level per pipeline stage.
// ---------------------------------------------------------------------------
`include "hilbert_curve_convert_top_defines.svh"

module hilbert_curve_convert_top #(
  parameter int MAX_ORDER = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hcc_pkg::ORDER_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              mode,
  input  logic [hcc_pkg::COORD_W-1:0]       x_coord,
  input  logic [hcc_pkg::COORD_W-1:0]       y_coord,
  input  logic [hcc_pkg::INDEX_W-1:0]       curve_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hcc_pkg::INDEX_W-1:0]       result_index,
  output logic [hcc_pkg::COORD_W-1:0]       result_x,
  output logic [hcc_pkg::COORD_W-1:0]       result_y
);

  localparam int LEVELS = (MAX_ORDER < hcc_pkg::HW_LEVELS) ? MAX_ORDER : hcc_pkg::HW_LEVELS;

  logic [hcc_pkg::ORDER_W-1:0] grid_order;
  logic [hcc_pkg::ORDER_W-1:0] ord;
  logic [hcc_pkg::COORD_W-1:0] cmask;
  logic                        en;

  hcc_pkg::hcc_word_t word  [LEVELS+1];
  logic               valid [LEVELS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_order <= hcc_pkg::GRID_ORDER_RESET;
    end else if (cfg_valid) begin
      grid_order <= cfg_data;
    end
  end

  assign ord   = (grid_order > hcc_pkg::ORDER_W'(LEVELS)) ? hcc_pkg::ORDER_W'(LEVELS)
                                                          : grid_order;
  assign cmask = hcc_pkg::coord_mask(ord);

  assign en       = !valid[LEVELS] || out_ready;
  assign in_ready = en;

  assign valid[0] = in_valid;
  assign word[0]  = (mode == hcc_pkg::MODE_TO_INDEX)
                  ? '{mode: mode, x: x_coord & cmask, y: y_coord & cmask, acc: '0}
                  : '{mode: mode, x: '0, y: '0, acc: curve_index};

  for (genvar k = 0; k < LEVELS; k++) begin : g_level
    hcc_level #(
      .DEC_BIT(LEVELS - 1 - k),
      .ENC_BIT(k)
    ) u_level (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ord      (ord),
      .in_valid (valid[k]),
      .in_word  (word[k]),
      .out_valid(valid[k+1]),
      .out_word (word[k+1])
    );
  end

  assign out_valid    = valid[LEVELS];
  assign result_index = (word[LEVELS].mode == hcc_pkg::MODE_TO_INDEX) ? word[LEVELS].acc : '0;
  assign result_x     = (word[LEVELS].mode == hcc_pkg::MODE_TO_COORD) ? word[LEVELS].x : '0;
  assign result_y     = (word[LEVELS].mode == hcc_pkg::MODE_TO_COORD) ? word[LEVELS].y : '0;

  `HCC_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !out_valid, "result valid straight after reset")
  `HCC_ASSERT(a_one_result_kind, out_valid && (result_index != '0) |-> (result_x == '0) && (result_y == '0), "index and coordinates both set")
  `HCC_ASSERT(a_index_range, out_valid |-> (result_index & ~hcc_pkg::index_mask(ord)) == '0, "index beyond grid order")
  `HCC_ASSERT(a_coord_range, out_valid |-> ((result_x | result_y) & ~cmask) == '0, "coordinate beyond grid order")

endmodule

### sv/hcc_level.sv
// ---------------------------------------------------------------------------
// Hilbert converter level stage
// One curve level, both directions, followed by the stage register.
// ---------------------------------------------------------------------------
module hcc_level #(
  parameter int DEC_BIT = 0,
  parameter int ENC_BIT = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic [hcc_pkg::ORDER_W-1:0]     ord,
  input  logic                            in_valid,
  input  hcc_pkg::hcc_word_t              in_word,
  output logic                            out_valid,
  output hcc_pkg::hcc_word_t              out_word
);

  localparam logic [hcc_pkg::COORD_W-1:0] DEC_MASK =
    hcc_pkg::COORD_W'((32'd1 << DEC_BIT) - 32'd1);
  localparam logic [hcc_pkg::COORD_W-1:0] ENC_MASK =
    hcc_pkg::COORD_W'((32'd1 << ENC_BIT) - 32'd1);

  function automatic logic [2*hcc_pkg::COORD_W-1:0] turn(
    input logic [hcc_pkg::COORD_W-1:0] a,
    input logic [hcc_pkg::COORD_W-1:0] b,
    input logic                        rx,
    input logic                        ry,
    input logic [hcc_pkg::COORD_W-1:0] m
  );
    logic [hcc_pkg::COORD_W-1:0] p;
    logic [hcc_pkg::COORD_W-1:0] q;
    p = a;
    q = b;
    if (!ry) begin
      if (rx) begin
        p = m & ~a;
        q = m & ~b;
      end
      return {q, p};
    end
    return {p, q};
  endfunction

  hcc_pkg::hcc_word_t           w;
  logic                         rx;
  logic                         ry;
  logic [2*hcc_pkg::COORD_W-1:0] xy;

  always_comb begin
    w  = in_word;
    rx = 1'b0;
    ry = 1'b0;
    xy = {in_word.x, in_word.y};
    if (in_word.mode == hcc_pkg::MODE_TO_INDEX) begin
      if (hcc_pkg::ORDER_W'(DEC_BIT) < ord) begin
        rx = in_word.x[DEC_BIT];
        ry = in_word.y[DEC_BIT];
        w.acc[2*DEC_BIT +: 2] = {rx, rx ^ ry};
        xy = turn(in_word.x & DEC_MASK, in_word.y & DEC_MASK, rx, ry, DEC_MASK);
        w.x = xy[2*hcc_pkg::COORD_W-1:hcc_pkg::COORD_W];
        w.y = xy[hcc_pkg::COORD_W-1:0];
      end
    end else begin
      if (hcc_pkg::ORDER_W'(ENC_BIT) < ord) begin
        rx = in_word.acc[2*ENC_BIT+1];
        ry = in_word.acc[2*ENC_BIT] ^ rx;
        xy = turn(in_word.x, in_word.y, rx, ry, ENC_MASK);
        w.x = xy[2*hcc_pkg::COORD_W-1:hcc_pkg::COORD_W];
        w.y = xy[hcc_pkg::COORD_W-1:0];
        w.x[ENC_BIT] = rx;
        w.y[ENC_BIT] = ry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= w;
    end
  end

endmodule

### tb/tb_hilbert_curve_convert_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Hilbert curve converter testbench
// Sends coordinate and index words at several grid orders (zero, one, the
// saturating values and random ones in between) and compares each result
// word with an in-bench model of the curve, under random sender bursts and
// receiver stalls.
// ---------------------------------------------------------------------------
module tb_hilbert_curve_convert_top;

  localparam int MAX_ORDER    = 16;
  localparam int PIPE_LATENCY = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int unsigned QUAD_CODE = 3;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PERIODIC,
    READY_BURSTY
  } ready_style_t;

  typedef struct packed {
    logic [hcc_pkg::INDEX_W-1:0] index;
    logic [hcc_pkg::COORD_W-1:0] x;
    logic [hcc_pkg::COORD_W-1:0] y;
  } curve_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [hcc_pkg::ORDER_W-1:0] cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        mode = hcc_pkg::MODE_TO_INDEX;
  logic [hcc_pkg::COORD_W-1:0] x_coord = '0;
  logic [hcc_pkg::COORD_W-1:0] y_coord = '0;
  logic [hcc_pkg::INDEX_W-1:0] curve_index = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [hcc_pkg::INDEX_W-1:0] result_index;
  logic [hcc_pkg::COORD_W-1:0] result_x;
  logic [hcc_pkg::COORD_W-1:0] result_y;

  curve_result_t               pending_results[$];
  logic [hcc_pkg::ORDER_W-1:0] order_shadow = hcc_pkg::GRID_ORDER_RESET;
  int                          mismatch_count = 0;
  int                          cycle_count = 0;
  ready_style_t                ready_style = READY_ALWAYS;
  int                          ready_tick = 0;
  int                          stall_left = 0;
  bit                          sender_gaps = 1'b0;
  int                          burst_left = 0;

  hilbert_curve_convert_top #(.MAX_ORDER(MAX_ORDER)) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .curve_index  (curve_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_index (result_index),
    .result_x     (result_x),
    .result_y     (result_y)
  );

  always #6 clk = ~clk;

  function automatic int unsigned effective_order(
    input logic [hcc_pkg::ORDER_W-1:0] reg_val
  );
    int unsigned o;
    o = 32'(reg_val);
    if (o > MAX_ORDER) o = MAX_ORDER;
    if (o > 16) o = 16;
    return o;
  endfunction

  // rotate or flip the part of (x, y) below bit lvl
  function automatic void turn_quadrant(input int unsigned lvl, inout int unsigned x,
                                        inout int unsigned y, input int unsigned rx,
                                        input int unsigned ry);
    int unsigned m;
    int unsigned t;
    m = (32'd1 << lvl) - 1;
    if (ry == 0) begin
      if (rx == 1) begin
        x = m & ~x;
        y = m & ~y;
      end
      t = x;
      x = y;
      y = t;
    end
  endfunction

  function automatic curve_result_t hilbert_convert(
    input logic                        m,
    input logic [hcc_pkg::COORD_W-1:0] xc,
    input logic [hcc_pkg::COORD_W-1:0] yc,
    input logic [hcc_pkg::INDEX_W-1:0] idx,
    input logic [hcc_pkg::ORDER_W-1:0] order_reg
  );
    curve_result_t r;
    int unsigned   ord, mask, x, y, d, t, b, rx, ry;
    ord  = effective_order(order_reg);
    mask = (32'd1 << ord) - 1;
    r    = '0;
    if (m == hcc_pkg::MODE_TO_INDEX) begin
      x = 32'(xc) & mask;
      y = 32'(yc) & mask;
      d = 0;
      for (int lvl = ord; lvl > 0; lvl--) begin
        b  = lvl - 1;
        rx = (x >> b) & 1;
        ry = (y >> b) & 1;
        d += ((QUAD_CODE * rx) ^ ry) << (2 * b);
        x &= (32'd1 << b) - 1;
        y &= (32'd1 << b) - 1;
        turn_quadrant(b, x, y, rx, ry);
      end
      r.index = d;
    end else begin
      t = idx;
      x = 0;
      y = 0;
      for (int lvl = 0; lvl < ord; lvl++) begin
        rx = (t >> 1) & 1;
        ry = (t ^ rx) & 1;
        turn_quadrant(lvl, x, y, rx, ry);
        x += rx << lvl;
        y += ry << lvl;
        t >>= 2;
      end
      r.x = hcc_pkg::COORD_W'(x);
      r.y = hcc_pkg::COORD_W'(y);
    end
    return r;
  endfunction

  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
  endfunction

  // model update and result check
  always @(posedge clk) begin : monitor
    curve_result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) order_shadow = cfg_data;
      if (in_valid && in_ready)
        pending_results.push_back(hilbert_convert(mode, x_coord, y_coord, curve_index,
                                                  order_shadow));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("unexpected result word, index", 32'd0, result_index);
        end else begin
          want = pending_results.pop_front();
          if (result_index !== want.index) flag_mismatch("result_index", want.index, result_index);
          if (result_x !== want.x) flag_mismatch("result_x", 32'(want.x), 32'(result_x));
          if (result_y !== want.y) flag_mismatch("result_y", 32'(want.y), 32'(result_y));
        end
      end
    end
  end

  always @(posedge clk) begin
    ready_tick++;
    case (ready_style)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      READY_PERIODIC: out_ready <= ((ready_tick % 5) != 4);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          stall_left = $urandom_range(1, 20);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic m, input logic [hcc_pkg::COORD_W-1:0] xc,
                           input logic [hcc_pkg::COORD_W-1:0] yc,
                           input logic [hcc_pkg::INDEX_W-1:0] idx);
    if (sender_gaps && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_valid    <= 1'b1;
    mode        <= m;
    x_coord     <= xc;
    y_coord     <= yc;
    curve_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold the sender until every outstanding word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_grid_order(input logic [hcc_pkg::ORDER_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] shaped_value(input int unsigned bits);
    logic [31:0] m;
    m = 32'((64'd1 << bits) - 1);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1, 2: return $urandom & m;
      default: return $urandom_range(0, 1) ? 32'd0 : m;
    endcase
  endfunction

  task automatic test_reset_extremes();
    send_word(hcc_pkg::MODE_TO_INDEX, 16'h0000, 16'h0000, 32'h0);
    send_word(hcc_pkg::MODE_TO_INDEX, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(hcc_pkg::MODE_TO_INDEX, 16'hFFFF, 16'h0000, 32'h0);
    send_word(hcc_pkg::MODE_TO_INDEX, 16'h0000, 16'hFFFF, 32'h0);
    send_word(hcc_pkg::MODE_TO_COORD, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
    send_word(hcc_pkg::MODE_TO_COORD, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    send_word(hcc_pkg::MODE_TO_COORD, 16'h0000, 16'h0000, 32'hAAAA_AAAA);
    send_word(hcc_pkg::MODE_TO_COORD, 16'h0000, 16'h0000, 32'h5555_5555);
  endtask

  // every quadrant both ways on the 2x2 grid
  task automatic test_order_one();
    write_grid_order(5'd1);
    for (int q = 0; q < 4; q++) begin
      send_word(hcc_pkg::MODE_TO_INDEX, hcc_pkg::COORD_W'(q & 1), hcc_pkg::COORD_W'(q >> 1),
                32'h0);
      send_word(hcc_pkg::MODE_TO_COORD, 16'h0, 16'h0, hcc_pkg::INDEX_W'(q));
    end
  endtask

  task automatic test_degenerate_orders();
    write_grid_order(5'd0);
    send_word(hcc_pkg::MODE_TO_INDEX, 16'hFFFF, 16'h1234, 32'h0);
    send_word(hcc_pkg::MODE_TO_COORD, 16'h0, 16'h0, 32'hFFFF_FFFF);
    write_grid_order(5'd31);
    send_word(hcc_pkg::MODE_TO_INDEX, 16'hFFFF, 16'h0000, 32'h0);
    send_word(hcc_pkg::MODE_TO_COORD, 16'h0, 16'h0, 32'hDEAD_BEEF);
  endtask

  // bits above the order must be ignored
  task automatic test_masking();
    write_grid_order(5'd3);
    send_word(hcc_pkg::MODE_TO_INDEX, 16'hABCD, 16'h1237, 32'h0);
    send_word(hcc_pkg::MODE_TO_COORD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFC5);
    send_word(hcc_pkg::MODE_TO_COORD, 16'h0, 16'h0, 32'h0000_0040);
  endtask

  task automatic test_random_phase(input logic [hcc_pkg::ORDER_W-1:0] order_val,
                                   input int count);
    int unsigned ord;
    logic        m;
    write_grid_order(order_val);
    ord = effective_order(order_val);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        sender_gaps = ($urandom_range(0, 3) != 0);
        ready_style = ready_style_t'($urandom_range(0, 3));
      end
      if (i == count / 2) drain_results();
      m = 1'($urandom_range(0, 1));
      send_word(m, hcc_pkg::COORD_W'(shaped_value(ord)), hcc_pkg::COORD_W'(shaped_value(ord)),
                shaped_value(2 * ord));
    end
  endtask

  task automatic test_random_sweep();
    test_random_phase(5'd16, 125);
    test_random_phase(5'd1, 125);
    test_random_phase(5'd2, 125);
    test_random_phase(5'd0, 125);
    test_random_phase(5'd31, 125);
    test_random_phase(5'd17, 125);
    test_random_phase(5'd8, 125);
    repeat (3) test_random_phase(hcc_pkg::ORDER_W'($urandom_range(1, 16)), 125);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    sender_gaps = 1'b1;
    ready_style = READY_RANDOM;
    test_reset_extremes();
    test_order_one();
    ready_style = READY_BURSTY;
    test_degenerate_orders();
    test_masking();
    test_random_sweep();
    drain_results();
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/hcc_pkg.sv
sv/hcc_level.sv
sv/hilbert_curve_convert_top.sv
tb/tb_hilbert_curve_convert_top.sv
